@@ hdl/qpht_pkg.sv @@
// Package for the quadratic-probing hash table: sizes, operation and status
// codes, and the request types passed between the controller and the slot store.
// No dependencies.
`timescale 1ns / 1ps

package qpht_pkg;

  // Number of slots. The home slot is taken from the low key bits, so this
  // must be a power of two.
  localparam int TABLE_SIZE = 16;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int CNT_W      = $clog2(TABLE_SIZE + 1);

  localparam int MODE_W   = 2;
  localparam int KEY_W    = 31;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 4;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [MODE_W-1:0] mode_t;
  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [VAL_W-1:0]  val_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [SLOT_W-1:0] slot_t;

  localparam mode_t MODE_INSERT = 2'd0;
  localparam mode_t MODE_SEARCH = 2'd1;
  localparam mode_t MODE_DELETE = 2'd2;

  localparam status_t STAT_INSERTED = 3'd0;
  localparam status_t STAT_UPDATED  = 3'd1;
  localparam status_t STAT_FULL     = 3'd2;
  localparam status_t STAT_FOUND    = 3'd3;
  localparam status_t STAT_DELETED  = 3'd4;
  localparam status_t STAT_NOTFOUND = 3'd5;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESP
  } state_t;

  // Write request into the slot store.
  typedef struct packed {
    logic ins;   // new record: key, value, used set, tombstone cleared
    logic upd;   // value overwrite of a live record
    logic del;   // set tombstone
    idx_t idx;
    key_t key;
    val_t value;
  } wr_req_t;

  // Registered read response from the slot store.
  typedef struct packed {
    idx_t idx;
    logic used;
    logic tomb;
    key_t key;
    val_t value;
  } rd_rsp_t;

endpackage

@@ hdl/qpht_if.sv @@
// Valid/ready channel interfaces for the hash table's request and result sides.
// Depends on qpht_pkg.
`timescale 1ns / 1ps

interface qpht_in_if import qpht_pkg::*; ();
  logic  valid;
  logic  ready;
  mode_t mode;
  key_t  key;
  val_t  value;

  modport source (output valid, mode, key, value, input ready);
  modport sink   (input valid, mode, key, value, output ready);
endinterface

interface qpht_out_if import qpht_pkg::*; ();
  logic    valid;
  logic    ready;
  status_t status;
  slot_t   slot;
  val_t    read_value;

  modport source (output valid, status, slot, read_value, input ready);
  modport sink   (input valid, status, slot, read_value, output ready);
endinterface

@@ hdl/qpht_probe.sv @@
// Probe address generator: while step is high, steps (home + i*i) mod TABLE_SIZE
// one probe a cycle by adding the running odd offset 2i+1. Depends on qpht_pkg.
`timescale 1ns / 1ps

module qpht_probe import qpht_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  idx_t home,
  input  logic step,
  output idx_t pos,
  output logic last,
  output logic exh
);

  localparam logic [IDX_W:0] SIZE_X = (IDX_W + 1)'(TABLE_SIZE);
  localparam logic [IDX_W:0] TWO_X  = (IDX_W + 1)'(2);

  idx_t pos_r, pos_nxt;
  idx_t odd_r, odd_nxt;
  cnt_t cnt_r, cnt_nxt;

  // Modular add of two values already below TABLE_SIZE.
  function automatic idx_t wrap_add(logic [IDX_W:0] a, logic [IDX_W:0] b);
    logic [IDX_W:0] s;
    s = a + b;
    if (s >= SIZE_X) begin
      s = s - SIZE_X;
    end
    return s[IDX_W-1:0];
  endfunction

  always_comb begin
    pos_nxt = pos_r;
    odd_nxt = odd_r;
    cnt_nxt = cnt_r;
    if (start) begin
      pos_nxt = home;
      odd_nxt = IDX_W'(1);
      cnt_nxt = '0;
    end else if (step) begin
      pos_nxt = wrap_add({1'b0, pos_r}, {1'b0, odd_r});
      odd_nxt = wrap_add({1'b0, odd_r}, TWO_X);
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    odd_r <= odd_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign pos  = pos_r;
  assign last = (cnt_r == CNT_W'(TABLE_SIZE - 1));
  assign exh  = (cnt_r == CNT_W'(TABLE_SIZE));

endmodule

@@ hdl/qpht_store.sv @@
// Slot store: key and value memories with a registered read port, plus the
// used and tombstone bits in flip-flops. Depends on qpht_pkg.
`timescale 1ns / 1ps

module qpht_store import qpht_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    rd_en,
  input  idx_t    rd_idx,
  output rd_rsp_t rd_rsp,
  input  wr_req_t wr
);

  key_t key_mem [TABLE_SIZE];
  val_t val_mem [TABLE_SIZE];

  logic [TABLE_SIZE-1:0] used_r, used_nxt;
  logic [TABLE_SIZE-1:0] tomb_r, tomb_nxt;
  rd_rsp_t rsp_r;

  always_ff @(posedge clk) begin
    if (wr.ins) begin
      key_mem[wr.idx] <= wr.key;
    end
    if (wr.ins || wr.upd) begin
      val_mem[wr.idx] <= wr.value;
    end
  end

  // The bits are read in the same clocked block as the memories, so a probe
  // sees the slot state as of the issuing cycle.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rsp_r.idx   <= rd_idx;
      rsp_r.used  <= used_r[rd_idx];
      rsp_r.tomb  <= tomb_r[rd_idx];
      rsp_r.key   <= key_mem[rd_idx];
      rsp_r.value <= val_mem[rd_idx];
    end
  end

  always_comb begin
    used_nxt = used_r;
    tomb_nxt = tomb_r;
    if (wr.ins) begin
      used_nxt[wr.idx] = 1'b1;
      tomb_nxt[wr.idx] = 1'b0;
    end
    if (wr.del) begin
      tomb_nxt[wr.idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      tomb_r <= '0;
    end else begin
      used_r <= used_nxt;
      tomb_r <= tomb_nxt;
    end
  end

  assign rd_rsp = rsp_r;

endmodule

@@ hdl/qpht_ctrl.sv @@
// Sequencer: takes a request, walks the probe sequence one slot read a cycle,
// decides on each returned slot and holds the result in the output register.
// Depends on qpht_pkg and the channel interfaces.
`timescale 1ns / 1ps

module qpht_ctrl import qpht_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  qpht_in_if.sink    in_ch,
  qpht_out_if.source out_ch,
  output logic    probe_start,
  output idx_t    probe_home,
  output logic    probe_step,
  input  logic    probe_last,
  input  logic    probe_exh,
  output logic    rd_en,
  input  rd_rsp_t rd_rsp,
  output wr_req_t wr
);

  state_t  state_r, state_nxt;
  mode_t   mode_r, mode_nxt;
  key_t    key_r, key_nxt;
  val_t    value_r, value_nxt;
  logic    pend_r, pend_nxt;
  logic    last_r, last_nxt;
  status_t res_status_r, res_status_nxt;
  slot_t   res_slot_r, res_slot_nxt;
  val_t    res_val_r, res_val_nxt;
  logic    out_valid_r, out_valid_nxt;
  status_t out_status_r, out_status_nxt;
  slot_t   out_slot_r, out_slot_nxt;
  val_t    out_val_r, out_val_nxt;

  logic is_free;
  logic is_live;

  assign is_free = !rd_rsp.used || rd_rsp.tomb;
  assign is_live = rd_rsp.used && !rd_rsp.tomb && (rd_rsp.key == key_r);

  // Home slot is the low key bits (TABLE_SIZE is a power of two).
  assign probe_home = in_ch.key[IDX_W-1:0];

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    key_nxt        = key_r;
    value_nxt      = value_r;
    pend_nxt       = 1'b0;
    last_nxt       = last_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_val_nxt    = res_val_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_val_nxt    = out_val_r;
    in_ch.ready    = 1'b0;
    probe_start    = 1'b0;
    probe_step     = 1'b0;
    rd_en          = 1'b0;
    wr             = '0;
    wr.idx         = rd_rsp.idx;
    wr.key         = key_r;
    wr.value       = value_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          mode_nxt    = in_ch.mode;
          key_nxt     = in_ch.key;
          value_nxt   = in_ch.value;
          probe_start = 1'b1;
          res_slot_nxt = '0;
          res_val_nxt  = '0;
          case (in_ch.mode) inside
            MODE_INSERT, MODE_SEARCH, MODE_DELETE: begin
              state_nxt = S_SCAN;
            end
            default: begin
              res_status_nxt = STAT_NOTFOUND;
              state_nxt      = S_RESP;
            end
          endcase
        end
      end

      S_SCAN: begin
        // Issue the next probe while the previous slot is being judged.
        rd_en      = !probe_exh;
        probe_step = rd_en;
        pend_nxt   = rd_en;
        last_nxt   = probe_last;
        if (pend_r) begin
          if (mode_r == MODE_INSERT) begin
            if (is_free) begin
              wr.ins         = 1'b1;
              res_status_nxt = STAT_INSERTED;
              res_slot_nxt   = SLOT_W'(rd_rsp.idx);
              state_nxt      = S_RESP;
            end else if (is_live) begin
              wr.upd         = 1'b1;
              res_status_nxt = STAT_UPDATED;
              res_slot_nxt   = SLOT_W'(rd_rsp.idx);
              state_nxt      = S_RESP;
            end else if (last_r) begin
              res_status_nxt = STAT_FULL;
              state_nxt      = S_RESP;
            end
          end else begin
            if (!rd_rsp.used) begin
              res_status_nxt = STAT_NOTFOUND;
              state_nxt      = S_RESP;
            end else if (is_live) begin
              res_slot_nxt = SLOT_W'(rd_rsp.idx);
              if (mode_r == MODE_SEARCH) begin
                res_status_nxt = STAT_FOUND;
                res_val_nxt    = rd_rsp.value;
              end else begin
                wr.del         = 1'b1;
                res_status_nxt = STAT_DELETED;
              end
              state_nxt = S_RESP;
            end else if (last_r) begin
              res_status_nxt = STAT_NOTFOUND;
              state_nxt      = S_RESP;
            end
          end
          if (state_nxt == S_RESP) begin
            pend_nxt = 1'b0;
          end
        end
      end

      S_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = res_slot_r;
          out_val_nxt    = res_val_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    key_r        <= key_nxt;
    value_r      <= value_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_val_r    <= res_val_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_val_r    <= out_val_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.slot       = out_slot_r;
  assign out_ch.read_value = out_val_r;

endmodule

@@ hdl/quadratic_probe_hash_table.sv @@
// An accepted request starts the probe generator at the home slot. Each probe reads
// a slot into the store's read register, and the controller judges it while the next
// probe issues. A decision moves to the result state, which loads the result register;
// an unused mode code goes straight there. The block takes no new request
// until the result register is loaded; a stalled result keeps it in the result state.
// Reset (synchronous, active low) clears the used and tombstone bits and the
// control state; key and value memories are not cleared.
`timescale 1ns / 1ps

module quadratic_probe_hash_table import qpht_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  qpht_in_if.sink    in_ch,
  qpht_out_if.source out_ch
);

  logic    probe_start;
  idx_t    probe_home;
  logic    probe_step;
  idx_t    probe_pos;
  logic    probe_last;
  logic    probe_exh;
  logic    rd_en;
  rd_rsp_t rd_rsp;
  wr_req_t wr;

  qpht_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .probe_start (probe_start),
    .probe_home  (probe_home),
    .probe_step  (probe_step),
    .probe_last  (probe_last),
    .probe_exh   (probe_exh),
    .rd_en       (rd_en),
    .rd_rsp      (rd_rsp),
    .wr          (wr)
  );

  qpht_probe u_probe (
    .clk   (clk),
    .rst_n (rst_n),
    .start (probe_start),
    .home  (probe_home),
    .step  (probe_step),
    .pos   (probe_pos),
    .last  (probe_last),
    .exh   (probe_exh)
  );

  qpht_store u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (rd_en),
    .rd_idx (probe_pos),
    .rd_rsp (rd_rsp),
    .wr     (wr)
  );

endmodule

@@ hdl/qpht_checker.sv @@
// Port-level checks for the hash table, attached to the top level by bind.
// Depends on qpht_pkg and quadratic_probe_hash_table.
`timescale 1ns / 1ps

module qpht_checker import qpht_pkg::*; (
  input logic    clk,
  input logic    rst_n,
  input logic    in_valid,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input status_t out_status,
  input slot_t   out_slot,
  input val_t    out_read_value
);

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_slot) && $stable(out_read_value))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // One request at a time: the block is busy right after taking one.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_FULL || out_status == STAT_NOTFOUND)
      |-> out_slot == '0 && out_read_value == '0)
    else $error("miss result carries slot or data");

  a_data_found_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STAT_FOUND |-> out_read_value == '0)
    else $error("data word on a result that is not a hit");

endmodule

bind quadratic_probe_hash_table qpht_checker u_qpht_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_status     (out_ch.status),
  .out_slot       (out_ch.slot),
  .out_read_value (out_ch.read_value)
);

@@ tb/tb.sv @@
// Self-checking bench for quadratic_probe_hash_table: a directed table of requests, then
// random insert, search and delete traffic under four sender and receiver idling phases.
// Depends on qpht_pkg, the qpht_in_if and qpht_out_if interfaces, and the block itself.
`timescale 1ns / 1ps

module tb;
  import qpht_pkg::*;

  localparam mode_t MODE_UNUSED     = 2'd3;
  localparam key_t  KEY_MAX         = 31'h7FFF_FFFF;
  localparam int    DRAIN_CYCLES    = TABLE_SIZE + 4;
  localparam int    ITEMS_PER_PHASE = 181;
  localparam int    N_DIR           = 25;
  localparam int    N_PHASES        = 4;
  localparam int    POOL_SIZE       = 16;

  typedef struct packed {
    status_t status;
    slot_t   slot;
    val_t    read_value;
  } result_t;

  typedef struct packed {
    mode_t   mode;
    key_t    key;
    val_t    value;
    logic    typed;
    result_t res;
  } dir_row_t;

  // Rows with typed set carry their own expected result; the rest rely on the predictor.
  localparam dir_row_t DIR_TAB [N_DIR] = '{
    {MODE_SEARCH, 31'd0,   32'd0,           1'b1, {STAT_NOTFOUND, 4'd0,  32'd0}},
    {MODE_DELETE, KEY_MAX, 32'd0,           1'b1, {STAT_NOTFOUND, 4'd0,  32'd0}},
    {MODE_UNUSED, 31'd5,   32'hFFFF_FFFF,   1'b1, {STAT_NOTFOUND, 4'd0,  32'd0}},
    {MODE_INSERT, 31'd0,   32'd0,           1'b1, {STAT_INSERTED, 4'd0,  32'd0}},
    {MODE_INSERT, KEY_MAX, 32'hFFFF_FFFF,   1'b1, {STAT_INSERTED, 4'd15, 32'd0}},
    {MODE_SEARCH, KEY_MAX, 32'd0,           1'b1, {STAT_FOUND,    4'd15, 32'hFFFF_FFFF}},
    {MODE_INSERT, KEY_MAX, 32'h1234_5678,   1'b1, {STAT_UPDATED,  4'd15, 32'd0}},
    {MODE_SEARCH, KEY_MAX, 32'hDEAD_BEEF,   1'b0, {STAT_INSERTED, 4'd0,  32'd0}},
    {MODE_INSERT, 31'd16,  32'hA5A5_A5A5,   1'b0, {STAT_INSERTED, 4'd0,  32'd0}},
    {MODE_INSERT, 31'd32,  32'h5A5A_5A5A,   1'b0, {STAT_INSERTED, 4'd0,  32'd0}},
    {MODE_DELETE, 31'd16,  32'd0,           1'b0, {STAT_INSERTED, 4'd0,  32'd0}},
    {MODE_SEARCH, 31'd16,  32'd0,           1'b0, {STAT_INSERTED, 4'd0,  32'd0}},
    {MODE_SEARCH, 31'd32,  32'd0,           1'b0, {STAT_INSERTED, 4'd0,  32'd0}},
    {MODE_INSERT, 31'd32,  32'hC0FF_EE00,   1'b0, {STAT_INSERTED, 4'd0,  32'd0}},
    {MODE_UNUSED, 31'd32,  32'h8000_0001,   1'b1, {STAT_NOTFOUND, 4'd0,  32'd0}},
    {MODE_DELETE, 31'd32,  32'd0,           1'b0, {STAT_INSERTED, 4'd0,  32'd0}},
    {MODE_SEARCH, 31'd32,  32'd0,           1'b0, {STAT_INSERTED, 4'd0,  32'd0}},
    {MODE_INSERT, 31'd64,  32'h0000_0040,   1'b0, {STAT_INSERTED, 4'd0,  32'd0}},
    {MODE_INSERT, 31'd80,  32'h0000_0050,   1'b0, {STAT_INSERTED, 4'd0,  32'd0}},
    {MODE_INSERT, 31'd96,  32'h0000_0060,   1'b1, {STAT_FULL,     4'd0,  32'd0}},
    {MODE_SEARCH, 31'd128, 32'd0,           1'b1, {STAT_NOTFOUND, 4'd0,  32'd0}},
    {MODE_DELETE, 31'd96,  32'd0,           1'b1, {STAT_NOTFOUND, 4'd0,  32'd0}},
    {MODE_DELETE, 31'd0,   32'd0,           1'b0, {STAT_INSERTED, 4'd0,  32'd0}},
    {MODE_INSERT, 31'd96,  32'h0000_0096,   1'b0, {STAT_INSERTED, 4'd0,  32'd0}},
    {MODE_SEARCH, 31'd80,  32'd0,           1'b0, {STAT_INSERTED, 4'd0,  32'd0}}
  };

  localparam int SEND_IDLE_PCT  [N_PHASES] = '{0, 58, 0, 15};
  localparam int RECV_STALL_PCT [N_PHASES] = '{0, 0, 58, 15};

  logic clk;
  logic rst_n;

  qpht_in_if  in_ch ();
  qpht_out_if out_ch ();

  quadratic_probe_hash_table u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow copy of the slot store.
  key_t tbl_key  [TABLE_SIZE];
  val_t tbl_val  [TABLE_SIZE];
  bit   tbl_used [TABLE_SIZE];
  bit   tbl_tomb [TABLE_SIZE];

  result_t pending_q [$];
  key_t    key_pool [POOL_SIZE];
  result_t want;
  int      fail_count     = 0;
  int      send_idle_pct  = 0;
  int      recv_stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAIL quadratic_probe_hash_table");
    $finish;
  end

  // Applies one request to the shadow table and returns the result it should produce.
  function automatic result_t apply_table_op(mode_t m, key_t k, val_t v);
    result_t r;
    int      home;
    int      s;
    bit      done;
    r.status     = STAT_NOTFOUND;
    r.slot       = '0;
    r.read_value = '0;
    home = int'(k % TABLE_SIZE);
    done = 1'b0;
    if (m == MODE_INSERT) begin
      r.status = STAT_FULL;
      for (int i = 0; i < TABLE_SIZE && !done; i++) begin
        s = (home + i * i) % TABLE_SIZE;
        if (!tbl_used[s] || tbl_tomb[s]) begin
          tbl_key[s]  = k;
          tbl_val[s]  = v;
          tbl_used[s] = 1'b1;
          tbl_tomb[s] = 1'b0;
          r.status    = STAT_INSERTED;
          r.slot      = slot_t'(s);
          done        = 1'b1;
        end else if (tbl_key[s] == k) begin
          tbl_val[s] = v;
          r.status   = STAT_UPDATED;
          r.slot     = slot_t'(s);
          done       = 1'b1;
        end
      end
    end else if (m == MODE_SEARCH || m == MODE_DELETE) begin
      for (int i = 0; i < TABLE_SIZE && !done; i++) begin
        s = (home + i * i) % TABLE_SIZE;
        // A never-used slot ends the probe; tombstones are stepped over.
        if (!tbl_used[s]) begin
          done = 1'b1;
        end else if (!tbl_tomb[s] && tbl_key[s] == k) begin
          r.slot = slot_t'(s);
          done   = 1'b1;
          if (m == MODE_SEARCH) begin
            r.status     = STAT_FOUND;
            r.read_value = tbl_val[s];
          end else begin
            tbl_tomb[s] = 1'b1;
            r.status    = STAT_DELETED;
          end
        end
      end
    end
    return r;
  endfunction

  task automatic report_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, exp_v, act_v);
    end
  endtask

  // Holds valid high with the payload until the request is taken, then predicts it.
  task automatic send_request(input mode_t m, input key_t k, input val_t v,
                              input logic typed, input result_t fixed);
    int      gap;
    result_t got;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode  <= m;
    in_ch.key   <= k;
    in_ch.value <= v;
    do @(posedge clk); while (!in_ch.ready);
    got = apply_table_op(m, k, v);
    pending_q.push_back(typed ? fixed : got);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("%0t: unexpected result: status %0d slot %0d value %0h", $time,
                   out_ch.status, out_ch.slot, out_ch.read_value);
        end
      end else begin
        want = pending_q.pop_front();
        if (out_ch.status !== want.status) report_field("status", want.status, out_ch.status);
        if (out_ch.slot !== want.slot) report_field("slot", want.slot, out_ch.slot);
        if (out_ch.read_value !== want.read_value) begin
          report_field("read_value", want.read_value, out_ch.read_value);
        end
      end
    end
  end

  initial begin : stimulus
    mode_t m;
    key_t  k;
    int    roll;
    in_ch.valid  <= 1'b0;
    in_ch.mode   <= MODE_INSERT;
    in_ch.key    <= '0;
    in_ch.value  <= '0;
    rst_n        <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < N_DIR; r++) begin
      send_request(DIR_TAB[r].mode, DIR_TAB[r].key, DIR_TAB[r].value,
                   DIR_TAB[r].typed, DIR_TAB[r].res);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      send_idle_pct  = SEND_IDLE_PCT[ph];
      recv_stall_pct = RECV_STALL_PCT[ph];
      // Pool keys crowd a few home slots so that collisions, hits and tombstones are common.
      for (int j = 0; j < POOL_SIZE; j++) begin
        key_pool[j] = key_t'($urandom);
        key_pool[j][IDX_W-1:0] = idx_t'($urandom_range(0, 5));
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 49) == 0) drain_results();
        roll = $urandom_range(0, 99);
        if (roll < 40) m = MODE_INSERT;
        else if (roll < 70) m = MODE_SEARCH;
        else if (roll < 95) m = MODE_DELETE;
        else m = MODE_UNUSED;
        if ($urandom_range(0, 99) < 75) k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        else k = key_t'($urandom);
        send_request(m, k, val_t'($urandom), 1'b0, '0);
      end
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_q.size() == 0) begin
      $display("PASS quadratic_probe_hash_table");
    end else begin
      $display("FAIL quadratic_probe_hash_table");
    end
    $finish;
  end

endmodule
